// File: rtl/tspf_pkg.sv
// ----------------------------------------------------------------------------
// tspf_pkg
// Shared types and constants of the transport stream PID filter with
// continuity counter check.
// ----------------------------------------------------------------------------
`default_nettype none

package tspf_pkg;

    // stream framing
    localparam int              PACKET_BYTES   = 188;
    localparam int              POS_BITS       = 8;
    localparam logic [7:0]      LAST_POS       = 8'(PACKET_BYTES - 1);
    localparam logic [7:0]      POS_SYNC       = 8'd0;
    localparam logic [7:0]      POS_PID_HI     = 8'd1;
    localparam logic [7:0]      POS_PID_LO     = 8'd2;
    localparam logic [7:0]      POS_CC         = 8'd3;
    localparam logic [7:0]      SYNC_BYTE      = 8'h47;

    // header fields
    localparam int              PID_BITS       = 13;
    localparam int              CC_BITS        = 4;
    localparam int              PID_HI_BITS    = 5;
    localparam logic [12:0]     NULL_PID       = 13'h1fff;

    // configuration port
    localparam int              CFG_INDEX_BITS = 3;

    // result kinds
    localparam logic            KIND_BYTE      = 1'b0;
    localparam logic            KIND_SYNC_ERR  = 1'b1;

    // shown error total
    localparam int              TOTAL_BITS     = 16;
    localparam logic [15:0]     TOTAL_MAX      = 16'hffff;

    // queue between front and back
    localparam int              QUEUE_DEPTH    = 8;
    localparam int              QPTR_BITS      = 3;
    localparam int              QCNT_BITS      = 4;

    // beats of a header entry: three held bytes then the counter byte
    localparam logic [1:0]      PHASE_HOLD0    = 2'd0;
    localparam logic [1:0]      PHASE_HOLD1    = 2'd1;
    localparam logic [1:0]      PHASE_HOLD2    = 2'd2;
    localparam logic [1:0]      PHASE_LAST     = 2'd3;

    // one queued action for the back end
    typedef struct packed {
        logic                   kind;
        logic                   hdr;
        logic [2:0][7:0]        hold;
        logic [7:0]             data;
        logic                   last;
        logic                   cc_bad;
        logic [TOTAL_BITS-1:0]  total;
    } tspf_entry_t;

    // queue status toward its neighbors
    typedef struct packed {
        logic                   full;
        logic                   empty;
    } tspf_qstat_t;

endpackage : tspf_pkg

`default_nettype wire

// File: rtl/tspf_front.sv
// ----------------------------------------------------------------------------
// tspf_front
// Accepts stream bytes, tracks packet position, holds the header, matches
// the PID against the slots and checks the continuity counter. Each byte
// that causes output becomes one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module tspf_front #(
    parameter int PID_SLOTS        = 6,
    parameter int ERROR_COUNT_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           stream_byte,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tspf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tspf_pkg::PID_BITS-1:0]        cfg_data,
    input  wire tspf_pkg::tspf_qstat_t                qstat,
    output logic                                      push,
    output tspf_pkg::tspf_entry_t                     push_entry
);
    import tspf_pkg::*;

    localparam int                    CW       = (ERROR_COUNT_BITS > TOTAL_BITS) ?
                                                 ERROR_COUNT_BITS : TOTAL_BITS;
    localparam logic [ERROR_COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [POS_BITS-1:0]            pos_reg, pos_next;
    logic [2:0][7:0]                hold_reg, hold_next;
    logic                           passing_reg, passing_next;
    logic                           ccbad_reg, ccbad_next;
    logic [PID_BITS-1:0]            slot_reg [PID_SLOTS];
    logic [PID_BITS-1:0]            slot_next [PID_SLOTS];
    logic [CC_BITS-1:0]             exp_reg [PID_SLOTS];
    logic [CC_BITS-1:0]             exp_next [PID_SLOTS];
    logic [PID_SLOTS-1:0]           seen_reg, seen_next;
    logic [ERROR_COUNT_BITS-1:0]    count_reg, count_next;

    logic                           accept;
    logic [PID_BITS-1:0]            pid;
    logic [CC_BITS-1:0]             cc;
    logic [PID_SLOTS-1:0]           hit;
    logic                           found;
    logic                           hdr_ok;
    logic                           hit_any;
    logic [CC_BITS-1:0]             exp_sel;
    logic                           seen_sel;
    logic                           cc_mismatch;
    logic [CW-1:0]                  count_ext;
    logic [TOTAL_BITS-1:0]          shown;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = qstat.full;
    assign cfg_ready = 1'b1;

    // header fields
    assign pid    = {hold_reg[1][PID_HI_BITS-1:0], hold_reg[2]};
    assign cc     = stream_byte[CC_BITS-1:0];
    assign hdr_ok = (hold_reg[0] == SYNC_BYTE) && (pid != NULL_PID);

    // lowest numbered matching slot wins
    always_comb
    begin
        found    = 1'b0;
        exp_sel  = '0;
        seen_sel = 1'b0;
        for (int s = 0; s < PID_SLOTS; s++)
        begin
            hit[s] = (slot_reg[s] == pid) && !found;
            found  = found || (slot_reg[s] == pid);
            if (hit[s])
            begin
                exp_sel  = exp_reg[s];
                seen_sel = seen_reg[s];
            end
        end
    end

    assign hit_any     = hdr_ok && found;
    assign cc_mismatch = seen_sel && (exp_sel != cc);

    // clamped error total as shown on the output
    assign count_ext = CW'(count_next);
    assign shown     = (count_ext > CW'(TOTAL_MAX)) ? TOTAL_MAX : count_ext[TOTAL_BITS-1:0];

    // next state and queue entry
    always_comb
    begin
        pos_next     = pos_reg;
        hold_next    = hold_reg;
        passing_next = passing_reg;
        ccbad_next   = ccbad_reg;
        seen_next    = seen_reg;
        count_next   = count_reg;
        for (int s = 0; s < PID_SLOTS; s++)
        begin
            slot_next[s] = slot_reg[s];
            exp_next[s]  = exp_reg[s];
        end

        push              = 1'b0;
        push_entry.kind   = KIND_BYTE;
        push_entry.hdr    = 1'b0;
        push_entry.hold   = hold_reg;
        push_entry.data   = stream_byte;
        push_entry.last   = (pos_reg == LAST_POS);
        push_entry.cc_bad = ccbad_reg;
        push_entry.total  = shown;

        if (accept)
        begin
            pos_next = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
            priority if (pos_reg == POS_SYNC)
            begin
                hold_next[0] = stream_byte;
                passing_next = 1'b0;
                ccbad_next   = 1'b0;
                if (stream_byte != SYNC_BYTE)
                begin
                    push              = 1'b1;
                    push_entry.kind   = KIND_SYNC_ERR;
                    push_entry.data   = '0;
                    push_entry.last   = 1'b0;
                    push_entry.cc_bad = 1'b0;
                end
            end
            else if (pos_reg == POS_PID_HI)
            begin
                hold_next[1] = stream_byte;
            end
            else if (pos_reg == POS_PID_LO)
            begin
                hold_next[2] = stream_byte;
            end
            else if (pos_reg == POS_CC)
            begin
                passing_next = hit_any;
                ccbad_next   = hit_any && cc_mismatch;
                if (hit_any)
                begin
                    for (int s = 0; s < PID_SLOTS; s++)
                    begin
                        if (hit[s])
                        begin
                            exp_next[s]  = cc + 1'b1;
                            seen_next[s] = 1'b1;
                        end
                    end
                    if (cc_mismatch && (count_reg != COUNT_MAX))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    push              = 1'b1;
                    push_entry.hdr    = 1'b1;
                    push_entry.cc_bad = cc_mismatch;
                end
            end
            else
            begin
                push = passing_reg;
            end
        end

        // slot register write restarts that slot's counter tracking
        if (cfg_valid && cfg_ready)
        begin
            for (int s = 0; s < PID_SLOTS; s++)
            begin
                if (cfg_index == CFG_INDEX_BITS'(s))
                begin
                    slot_next[s] = cfg_data;
                    seen_next[s] = 1'b0;
                end
            end
        end
    end

    // control and configuration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            passing_reg <= 1'b0;
            ccbad_reg   <= 1'b0;
            seen_reg    <= '0;
            count_reg   <= '0;
            for (int s = 0; s < PID_SLOTS; s++)
            begin
                slot_reg[s] <= NULL_PID;
                exp_reg[s]  <= '0;
            end
        end
        else
        begin
            pos_reg     <= pos_next;
            passing_reg <= passing_next;
            ccbad_reg   <= ccbad_next;
            seen_reg    <= seen_next;
            count_reg   <= count_next;
            for (int s = 0; s < PID_SLOTS; s++)
            begin
                slot_reg[s] <= slot_next[s];
                exp_reg[s]  <= exp_next[s];
            end
        end
    end

    // header bytes, written before they are read
    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
    end

    // at most one counter moves per packet
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit))
        else $error("more than one slot selected");

    // a passing packet never started with a bad sync byte
    a_pass_sync: assert property (@(posedge clk) disable iff (!rst_n)
        passing_reg && (pos_reg != POS_SYNC) && (pos_reg > POS_CC) |->
        (hold_reg[0] == SYNC_BYTE))
        else $error("packet passing without sync byte");

endmodule : tspf_front

`default_nettype wire

// File: rtl/tspf_queue.sv
// ----------------------------------------------------------------------------
// tspf_queue
// Small first-in first-out queue of entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tspf_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire tspf_pkg::tspf_entry_t  push_entry,
    input  wire logic                   pop,
    output tspf_pkg::tspf_entry_t       head,
    output tspf_pkg::tspf_qstat_t       qstat
);
    import tspf_pkg::*;

    tspf_entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                   do_push;
    logic                   do_pop;

    assign qstat.full  = (cnt_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign head        = mem_reg[rd_ptr_reg];

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("push into full queue");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_BITS'(QUEUE_DEPTH))
        else $error("queue fill beyond depth");

endmodule : tspf_queue

`default_nettype wire

// File: rtl/tspf_back.sv
// ----------------------------------------------------------------------------
// tspf_back
// Carries out queued entries: a header entry becomes four output beats,
// any other entry one. Drives the registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tspf_back (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire tspf_pkg::tspf_entry_t                  head,
    input  wire tspf_pkg::tspf_qstat_t                  qstat,
    output logic                                        pop,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic                                        result_kind,
    output logic [7:0]                                  out_byte,
    output logic                                        packet_end,
    output logic                                        cc_error,
    output logic [tspf_pkg::TOTAL_BITS-1:0]             error_total
);
    import tspf_pkg::*;

    logic [1:0]             phase_reg, phase_next;
    logic                   valid_reg, valid_next;
    logic                   kind_reg;
    logic [7:0]             byte_reg;
    logic                   end_reg;
    logic                   ccerr_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic                   load;
    logic                   final_beat;
    logic [7:0]             sel_byte;

    assign load       = !qstat.empty && (!valid_reg || !out_stall);
    assign final_beat = !head.hdr || (phase_reg == PHASE_LAST);
    assign pop        = load && final_beat;

    // byte of the current beat
    always_comb
    begin
        sel_byte = head.data;
        if (head.hdr)
        begin
            unique case (phase_reg)
                PHASE_HOLD0: sel_byte = head.hold[0];
                PHASE_HOLD1: sel_byte = head.hold[1];
                PHASE_HOLD2: sel_byte = head.hold[2];
                PHASE_LAST:  sel_byte = head.data;
                default:     sel_byte = head.data;
            endcase
        end
    end

    // beat sequencing and output valid
    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (load)
        begin
            phase_next = final_beat ? PHASE_HOLD0 : phase_reg + 1'b1;
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PHASE_HOLD0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= head.kind;
            byte_reg  <= sel_byte;
            end_reg   <= head.last && final_beat;
            ccerr_reg <= head.cc_bad;
            total_reg <= head.total;
        end
    end

    assign out_valid   = valid_reg;
    assign result_kind = kind_reg;
    assign out_byte    = byte_reg;
    assign packet_end  = end_reg;
    assign cc_error    = ccerr_reg;
    assign error_total = total_reg;

    // mid-header beats always belong to a header entry still queued
    a_phase_head: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PHASE_HOLD0) |-> (!qstat.empty && head.hdr))
        else $error("header beat without header entry");

    // a sync error report carries no packet flags
    a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && (kind_reg == KIND_SYNC_ERR) |->
        (byte_reg == '0) && !end_reg && !ccerr_reg)
        else $error("sync error report with packet flags");

endmodule : tspf_back

`default_nettype wire

// File: rtl/ts_pid_filter_cc_check_core.sv
// ----------------------------------------------------------------------------
// ts_pid_filter_cc_check_core
// Transport stream PID filter with per-slot continuity counter check.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_stall   stream_byte
//   output    out        out_valid / out_stall result_kind, out_byte,
//                                              packet_end, cc_error, error_total
//   config    in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle with no gaps; the front takes a byte every cycle the
// eight-entry queue is not full. The counter byte of a passed packet yields
// four beats; while the back drains them with no output stall, the queue
// holds at most four entries, and it drains during the next packet's header
// bytes. An accepted byte passes the queue and the output register to a beat.
// Reset clears position, packet flags, counters and slots (to the null PID).
// Output stall backs up the queue and then stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

module ts_pid_filter_cc_check_core #(
    parameter int PID_SLOTS        = 6,
    parameter int ERROR_COUNT_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           stream_byte,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic                                      result_kind,
    output logic [7:0]                                out_byte,
    output logic                                      packet_end,
    output logic                                      cc_error,
    output logic [tspf_pkg::TOTAL_BITS-1:0]           error_total,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tspf_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [tspf_pkg::PID_BITS-1:0]        cfg_data
);
    import tspf_pkg::*;

    tspf_qstat_t    qstat;
    tspf_entry_t    push_entry;
    tspf_entry_t    head;
    logic           push;
    logic           pop;

    // classify bytes and track counters
    tspf_front #(
        .PID_SLOTS        (PID_SLOTS),
        .ERROR_COUNT_BITS (ERROR_COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .stream_byte (stream_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .qstat       (qstat),
        .push        (push),
        .push_entry  (push_entry)
    );

    // decoupling queue
    tspf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    // expand entries into output beats
    tspf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .qstat       (qstat),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result_kind (result_kind),
        .out_byte    (out_byte),
        .packet_end  (packet_end),
        .cc_error    (cc_error),
        .error_total (error_total)
    );

endmodule : ts_pid_filter_cc_check_core

`default_nettype wire
